// ===== design/c_sl_pkg.sv =====
package c_sl_pkg;

  localparam int POS_BITS      = 16;
  localparam int KEYWORD_CHARS = 8;
  localparam int KW_COUNT      = 17;
  localparam int KW_WIN_BITS   = 64;
  localparam int FIFO_DEPTH    = 4;  // power of two
  localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

  localparam logic [5:0] K_LPAREN  = 6'd0;
  localparam logic [5:0] K_RPAREN  = 6'd1;
  localparam logic [5:0] K_LBRACE  = 6'd2;
  localparam logic [5:0] K_RBRACE  = 6'd3;
  localparam logic [5:0] K_COMMA   = 6'd4;
  localparam logic [5:0] K_DOT     = 6'd5;
  localparam logic [5:0] K_QUEST   = 6'd6;
  localparam logic [5:0] K_SEMI    = 6'd7;
  localparam logic [5:0] K_STAR    = 6'd8;
  localparam logic [5:0] K_SLASH   = 6'd9;
  localparam logic [5:0] K_NOT     = 6'd10;
  localparam logic [5:0] K_NE      = 6'd11;
  localparam logic [5:0] K_ASSIGN  = 6'd12;
  localparam logic [5:0] K_EQ      = 6'd13;
  localparam logic [5:0] K_LT      = 6'd14;
  localparam logic [5:0] K_LE      = 6'd15;
  localparam logic [5:0] K_GT      = 6'd16;
  localparam logic [5:0] K_GE      = 6'd17;
  localparam logic [5:0] K_PLUS    = 6'd18;
  localparam logic [5:0] K_INC     = 6'd19;
  localparam logic [5:0] K_MINUS   = 6'd20;
  localparam logic [5:0] K_DEC     = 6'd21;
  localparam logic [5:0] K_ANDAND  = 6'd22;
  localparam logic [5:0] K_AND     = 6'd23;
  localparam logic [5:0] K_OROR    = 6'd24;
  localparam logic [5:0] K_OR      = 6'd25;
  localparam logic [5:0] K_TILDE   = 6'd26;
  localparam logic [5:0] K_STRING  = 6'd27;
  localparam logic [5:0] K_INT     = 6'd28;
  localparam logic [5:0] K_IDENT   = 6'd29;
  localparam logic [5:0] K_KW_BASE = 6'd30;
  localparam logic [5:0] K_END     = 6'd47;

  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_UNKNOWN  = 3'd1;
  localparam logic [2:0] E_UNTERM   = 3'd2;
  localparam logic [2:0] E_IDENT_END = 3'd3;
  localparam logic [2:0] E_FRACTION = 3'd4;
  localparam logic [2:0] E_OVERFLOW = 3'd5;

  localparam logic [34:0] INT_MAX31 = 35'd2147483647;

  localparam logic [KW_WIN_BITS-1:0] KW_TEXT [KW_COUNT] = '{
    "break", "continue", "do", "else", "false", "for", "if", "return",
    "true", "while", "int", "void", "float", "char", "bool", "goto", "struct"
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd5, 4'd8, 4'd2, 4'd4, 4'd5, 4'd3, 4'd2, 4'd6,
    4'd4, 4'd5, 4'd3, 4'd4, 4'd5, 4'd4, 4'd4, 4'd4, 4'd6
  };

  typedef struct packed {
    logic [5:0]  kind;
    logic [2:0]  err;
    logic [15:0] start;
    logic [15:0] len;
    logic [30:0] val;
    logic        run_last;
    logic        stream_done;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic [15:0] to_start(input logic [POS_BITS-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return w[15:0];
  endfunction

  function automatic res_t mk_res(input logic [5:0] kind, input logic [2:0] err,
                                  input logic [POS_BITS-1:0] start,
                                  input logic [15:0] len, input logic [30:0] val);
    res_t r;
    r.kind        = kind;
    r.err         = err;
    r.start       = to_start(start);
    r.len         = len;
    r.val         = val;
    r.run_last    = 1'b0;
    r.stream_done = 1'b0;
    return r;
  endfunction

  function automatic logic [5:0] kw_kind(input logic [KW_WIN_BITS-1:0] win,
                                         input logic [15:0] len);
    logic [5:0]             k;
    logic [KW_WIN_BITS-1:0] mask;
    k = K_IDENT;
    if (len <= 16'(KEYWORD_CHARS) && len <= 16'd8) begin
      for (int i = 0; i < KW_COUNT; i++) begin
        if (KW_LEN[i] == 4'd8) begin
          mask = '1;
        end else begin
          mask = (KW_WIN_BITS'(1) << (8 * KW_LEN[i])) - KW_WIN_BITS'(1);
        end
        if (len == 16'(KW_LEN[i]) && (win & mask) == KW_TEXT[i]) begin
          k = K_KW_BASE + 6'(i);
        end
      end
    end
    return k;
  endfunction

endpackage

// ===== design/c_sl_if.sv =====
interface c_sl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface c_sl_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [2:0]  error_code;
  logic [15:0] start_pos;
  logic [15:0] token_length;
  logic [30:0] int_value;
  logic        run_last;
  logic        stream_done;

  modport source (output valid, output token_kind, output error_code, output start_pos,
                  output token_length, output int_value, output run_last,
                  output stream_done, input ready);
  modport sink (input valid, input token_kind, input error_code, input start_pos,
                input token_length, input int_value, input run_last,
                input stream_done, output ready);
endinterface

// ===== design/c_sl_core.sv =====
module c_sl_core (
  input  logic            clk,
  input  logic            rst,
  c_sl_in_if.sink         in_ch,
  input  logic            room,
  output c_sl_pkg::push_t push
);

  typedef enum logic [3:0] {
    M_IDLE, M_PEND, M_LINE, M_BLOCK, M_BSTAR, M_STR, M_NUM, M_IDENT
  } mode_t;

  localparam int PB = c_sl_pkg::POS_BITS;
  localparam int WB = c_sl_pkg::KW_WIN_BITS;

  logic          stage_valid;
  logic [7:0]    st_char;
  logic          st_last;
  logic          step;

  mode_t         mode, mode_next;
  logic [7:0]    pending_op, pending_op_next;
  logic [PB-1:0] token_start, token_start_next;
  logic [PB-1:0] char_pos, char_pos_next;
  logic [30:0]   int_accum, int_accum_next;
  logic          int_overflow, int_overflow_next;
  logic [WB-1:0] kw_win, kw_win_next;
  logic          halted, halted_next;
  logic [15:0]   tok_len, tok_len_next;

  logic                consumed;
  logic [34:0]         sum;
  c_sl_pkg::res_t      cand [4];
  logic [3:0]          cv;
  c_sl_pkg::res_t      slot0, slot1;
  logic [2:0]          n;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_id_start(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [5:0] op_single(input logic [7:0] p);
    logic [5:0] k;
    unique case (p)
      "/":     k = c_sl_pkg::K_SLASH;
      "!":     k = c_sl_pkg::K_NOT;
      "=":     k = c_sl_pkg::K_ASSIGN;
      "<":     k = c_sl_pkg::K_LT;
      ">":     k = c_sl_pkg::K_GT;
      "+":     k = c_sl_pkg::K_PLUS;
      "-":     k = c_sl_pkg::K_MINUS;
      "&":     k = c_sl_pkg::K_AND;
      default: k = c_sl_pkg::K_OR;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] op_double(input logic [7:0] p);
    logic [5:0] k;
    unique case (p)
      "!":     k = c_sl_pkg::K_NE;
      "=":     k = c_sl_pkg::K_EQ;
      "<":     k = c_sl_pkg::K_LE;
      ">":     k = c_sl_pkg::K_GE;
      "+":     k = c_sl_pkg::K_INC;
      "-":     k = c_sl_pkg::K_DEC;
      "&":     k = c_sl_pkg::K_ANDAND;
      default: k = c_sl_pkg::K_OROR;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] op_pair(input logic [7:0] p);
    return (p == "!" || p == "=" || p == "<" || p == ">") ? 8'("=") : p;
  endfunction

  assign step        = stage_valid && room;
  assign in_ch.ready = !stage_valid || room;

  assign sum = (35'(int_accum) << 3) + (35'(int_accum) << 1) + 35'(st_char - 8'("0"));

  always_comb begin
    mode_next         = mode;
    pending_op_next   = pending_op;
    token_start_next  = token_start;
    char_pos_next     = char_pos;
    int_accum_next    = int_accum;
    int_overflow_next = int_overflow;
    kw_win_next       = kw_win;
    halted_next       = halted;
    tok_len_next      = tok_len;
    consumed          = 1'b0;
    cv                = '0;
    for (int i = 0; i < 4; i++) begin
      cand[i] = '0;
    end

    if (!halted) begin
      unique case (mode)
        M_PEND: begin
          if (pending_op == "/" && (st_char == "/" || st_char == "*")) begin
            mode_next = (st_char == "/") ? M_LINE : M_BLOCK;
            consumed  = 1'b1;
          end else if (pending_op != "/" && st_char == op_pair(pending_op)) begin
            cv[0]     = 1'b1;
            cand[0]   = c_sl_pkg::mk_res(op_double(pending_op), c_sl_pkg::E_NONE,
                                         token_start, 16'd2, '0);
            mode_next = M_IDLE;
            consumed  = 1'b1;
          end else begin
            cv[0]     = 1'b1;
            cand[0]   = c_sl_pkg::mk_res(op_single(pending_op), c_sl_pkg::E_NONE,
                                         token_start, 16'd1, '0);
            mode_next = M_IDLE;
          end
        end
        M_LINE: begin
          if (st_char == "\n") mode_next = M_IDLE;
          consumed = 1'b1;
        end
        M_BLOCK: begin
          if (st_char == "*") mode_next = M_BSTAR;
          consumed = 1'b1;
        end
        M_BSTAR: begin
          if (st_char == "/") begin
            mode_next = M_IDLE;
          end else if (st_char != "*") begin
            mode_next = M_BLOCK;
          end
          consumed = 1'b1;
        end
        M_STR: begin
          tok_len_next = sat_inc(tok_len);
          if (st_char == "\"") begin
            cv[0]     = 1'b1;
            cand[0]   = c_sl_pkg::mk_res(c_sl_pkg::K_STRING, c_sl_pkg::E_NONE,
                                         token_start, tok_len_next, '0);
            mode_next = M_IDLE;
          end
          consumed = 1'b1;
        end
        M_NUM: begin
          if (is_digit(st_char)) begin
            if (!int_overflow) begin
              if (sum > c_sl_pkg::INT_MAX31) begin
                int_overflow_next = 1'b1;
              end else begin
                int_accum_next = sum[30:0];
              end
            end
            tok_len_next = sat_inc(tok_len);
            consumed     = 1'b1;
          end else if (st_char == ".") begin
            mode_next   = M_IDLE;
            cv[0]       = 1'b1;
            cand[0]     = c_sl_pkg::mk_res(c_sl_pkg::K_END, c_sl_pkg::E_FRACTION,
                                           token_start, sat_inc(tok_len), '0);
            halted_next = 1'b1;
            consumed    = 1'b1;
          end else begin
            mode_next = M_IDLE;
            cv[0]     = 1'b1;
            if (int_overflow) begin
              cand[0]     = c_sl_pkg::mk_res(c_sl_pkg::K_END, c_sl_pkg::E_OVERFLOW,
                                             token_start, tok_len, '0);
              halted_next = 1'b1;
            end else begin
              cand[0] = c_sl_pkg::mk_res(c_sl_pkg::K_INT, c_sl_pkg::E_NONE,
                                         token_start, tok_len, int_accum);
            end
          end
        end
        M_IDENT: begin
          if (is_id_start(st_char) || is_digit(st_char)) begin
            kw_win_next  = {kw_win[WB-9:0], st_char};
            tok_len_next = sat_inc(tok_len);
            consumed     = 1'b1;
          end else begin
            cv[0]     = 1'b1;
            cand[0]   = c_sl_pkg::mk_res(c_sl_pkg::kw_kind(kw_win, tok_len),
                                         c_sl_pkg::E_NONE, token_start, tok_len, '0);
            mode_next = M_IDLE;
          end
        end
        default: mode_next = M_IDLE;
      endcase

      if (!consumed && !halted_next) begin
        token_start_next = char_pos;
        unique case (st_char)
          "(", ")", "{", "}", ",", ".", "?", ";", "*", "~": begin
            cv[1] = 1'b1;
            unique case (st_char)
              "(":     cand[1].kind = c_sl_pkg::K_LPAREN;
              ")":     cand[1].kind = c_sl_pkg::K_RPAREN;
              "{":     cand[1].kind = c_sl_pkg::K_LBRACE;
              "}":     cand[1].kind = c_sl_pkg::K_RBRACE;
              ",":     cand[1].kind = c_sl_pkg::K_COMMA;
              ".":     cand[1].kind = c_sl_pkg::K_DOT;
              "?":     cand[1].kind = c_sl_pkg::K_QUEST;
              ";":     cand[1].kind = c_sl_pkg::K_SEMI;
              "*":     cand[1].kind = c_sl_pkg::K_STAR;
              default: cand[1].kind = c_sl_pkg::K_TILDE;
            endcase
            cand[1].start = c_sl_pkg::to_start(char_pos);
            cand[1].len   = 16'd1;
          end
          "/", "!", "=", "<", ">", "+", "-", "&", "|": begin
            mode_next       = M_PEND;
            pending_op_next = st_char;
          end
          "\"": begin
            mode_next    = M_STR;
            tok_len_next = 16'd1;
          end
          " ", "\t", 8'h0D, "\n": begin
          end
          default: begin
            if (is_digit(st_char)) begin
              mode_next         = M_NUM;
              int_accum_next    = 31'(st_char - 8'("0"));
              int_overflow_next = 1'b0;
              tok_len_next      = 16'd1;
            end else if (is_id_start(st_char)) begin
              mode_next    = M_IDENT;
              kw_win_next  = WB'(st_char);
              tok_len_next = 16'd1;
            end else begin
              cv[1]       = 1'b1;
              cand[1]     = c_sl_pkg::mk_res(c_sl_pkg::K_END, c_sl_pkg::E_UNKNOWN,
                                             char_pos, 16'd1, '0);
              halted_next = 1'b1;
            end
          end
        endcase
      end

      if (st_last && !halted_next) begin
        unique case (mode_next)
          M_PEND: begin
            cv[2]   = 1'b1;
            cand[2] = c_sl_pkg::mk_res(op_single(pending_op_next), c_sl_pkg::E_NONE,
                                       token_start_next, 16'd1, '0);
          end
          M_STR: begin
            cv[2]   = 1'b1;
            cand[2] = c_sl_pkg::mk_res(c_sl_pkg::K_END, c_sl_pkg::E_UNTERM,
                                       token_start_next, tok_len_next, '0);
          end
          M_NUM: begin
            cv[2] = 1'b1;
            if (int_overflow_next) begin
              cand[2] = c_sl_pkg::mk_res(c_sl_pkg::K_END, c_sl_pkg::E_OVERFLOW,
                                         token_start_next, tok_len_next, '0);
            end else begin
              cand[2] = c_sl_pkg::mk_res(c_sl_pkg::K_INT, c_sl_pkg::E_NONE,
                                         token_start_next, tok_len_next, int_accum_next);
            end
          end
          M_IDENT: begin
            cv[2]   = 1'b1;
            cand[2] = c_sl_pkg::mk_res(c_sl_pkg::K_END, c_sl_pkg::E_IDENT_END,
                                       token_start_next, tok_len_next, '0);
          end
          default: begin
          end
        endcase
      end
    end

    if (st_last && cv[2:0] == 3'b000) begin
      cv[3]   = 1'b1;
      cand[3] = c_sl_pkg::mk_res(c_sl_pkg::K_END, c_sl_pkg::E_NONE, char_pos, 16'd0, '0);
    end

    slot0 = '0;
    slot1 = '0;
    n     = '0;
    for (int i = 0; i < 4; i++) begin
      if (cv[i]) begin
        if (n == 3'd0) begin
          slot0 = cand[i];
        end else if (n == 3'd1) begin
          slot1 = cand[i];
        end
        n = n + 3'd1;
      end
    end
    if (n == 3'd1) begin
      slot0.run_last    = 1'b1;
      slot0.stream_done = st_last;
    end else if (n >= 3'd2) begin
      slot1.run_last    = 1'b1;
      slot1.stream_done = st_last;
    end

    if (st_last) begin
      mode_next         = M_IDLE;
      pending_op_next   = '0;
      token_start_next  = '0;
      char_pos_next     = '0;
      int_accum_next    = '0;
      int_overflow_next = 1'b0;
      kw_win_next       = '0;
      halted_next       = 1'b0;
      tok_len_next      = '0;
    end else begin
      char_pos_next = char_pos + PB'(1);
    end
  end

  assign push.cnt = step ? ((n >= 3'd2) ? 2'd2 : n[1:0]) : 2'd0;
  assign push.r0  = slot0;
  assign push.r1  = slot1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      mode         <= M_IDLE;
      pending_op   <= '0;
      token_start  <= '0;
      char_pos     <= '0;
      int_accum    <= '0;
      int_overflow <= 1'b0;
      kw_win       <= '0;
      halted       <= 1'b0;
      tok_len      <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        stage_valid <= 1'b1;
        st_char     <= in_ch.char_code;
        st_last     <= in_ch.last_char;
      end else if (step) begin
        stage_valid <= 1'b0;
      end
      if (step) begin
        mode         <= mode_next;
        pending_op   <= pending_op_next;
        token_start  <= token_start_next;
        char_pos     <= char_pos_next;
        int_accum    <= int_accum_next;
        int_overflow <= int_overflow_next;
        kw_win       <= kw_win_next;
        halted       <= halted_next;
        tok_len      <= tok_len_next;
      end
    end
  end

endmodule

// ===== design/c_sl_fifo.sv =====
module c_sl_fifo (
  input  logic            clk,
  input  logic            rst,
  input  c_sl_pkg::push_t push,
  output logic            room,
  c_sl_out_if.source      out_ch
);

  localparam int AW = c_sl_pkg::FIFO_AW;

  c_sl_pkg::res_t q [c_sl_pkg::FIFO_DEPTH];
  logic [AW-1:0]  wr, rd;
  logic [AW:0]    count;
  logic           pop;

  assign room = count <= (AW + 1)'(c_sl_pkg::FIFO_DEPTH - 2);
  assign pop  = out_ch.valid && out_ch.ready;

  assign out_ch.valid        = count != '0;
  assign out_ch.token_kind   = q[rd].kind;
  assign out_ch.error_code   = q[rd].err;
  assign out_ch.start_pos    = q[rd].start;
  assign out_ch.token_length = q[rd].len;
  assign out_ch.int_value    = q[rd].val;
  assign out_ch.run_last     = q[rd].run_last;
  assign out_ch.stream_done  = q[rd].stream_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      if (push.cnt != 2'd0) q[wr] <= push.r0;
      if (push.cnt == 2'd2) q[wr + AW'(1)] <= push.r1;
      wr    <= wr + AW'(push.cnt);
      rd    <= rd + AW'(pop);
      count <= count + (AW + 1)'(push.cnt) - (AW + 1)'(pop);
    end
  end

endmodule

// ===== design/c_subset_lexer_top.sv =====
// Channel  Dir  Word
// in_ch    in   char_code, last_char
// out_ch   out  token_kind, error_code, start_pos, token_length, int_value, run_last, stream_done
//
// One character per cycle while the queue has room: a character is registered, then lexed
// combinationally into a four-word result queue, whose head drives out_ch.
// A character producing two tokens pushes two words at once; the queue absorbs them.
// in_ch.ready drops while a character waits and the queue holds more than two words.
// Reset (rst, synchronous) returns the lexer to its idle state and empties the queue.
module c_subset_lexer_top (
  input logic        clk,
  input logic        rst,
  c_sl_in_if.sink    in_ch,
  c_sl_out_if.source out_ch
);

  c_sl_pkg::push_t push;
  logic            room;

  c_sl_core u_core (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .room  (room),
    .push  (push)
  );

  c_sl_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.cnt != 2'd0) |-> room)
    else $error("token push without queue room");

  a_one_last: assert property (@(posedge clk) disable iff (rst)
    (push.cnt == 2'd1) |-> push.r0.run_last)
    else $error("single token push missing run_last");

  a_two_last: assert property (@(posedge clk) disable iff (rst)
    (push.cnt == 2'd2) |-> (!push.r0.run_last && !push.r0.stream_done && push.r1.run_last))
    else $error("two token push has wrong run_last marks");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.stream_done) |-> out_ch.run_last)
    else $error("stream_done word without run_last");

endmodule
